@@ hdl/h4sec_pkg.sv @@
package h4sec_pkg;

   // Event framing
   localparam logic [7:0] INDICATOR_EVT    = 8'h04;
   localparam logic [7:0] EVT_CMD_COMPLETE = 8'h0e;
   localparam logic [7:0] EVT_CMD_STATUS   = 8'h0f;
   localparam logic [8:0] FRAME_HDR_LEN    = 9'd3;
   localparam int         FRAME_CNT_W      = 9;

   // Fixed reply layout
   localparam int         REPLY_FIXED_LEN  = 7;
   localparam logic [8:0] CC_MIN_LEN       = 9'd6;
   localparam logic [8:0] CS_LEN           = 9'd7;
   localparam logic [8:0] ENABLE_LEN       = 9'd9;

   // Version register
   localparam int         CFG_VERSION_BYTES = 6;
   localparam int         VERSION_W         = 8 * CFG_VERSION_BYTES;

   // Setup steps
   localparam logic [2:0] STEP_PSKEY  = 3'd0;
   localparam logic [2:0] STEP_RF     = 3'd1;
   localparam logic [2:0] STEP_ENABLE = 3'd2;
   localparam logic [2:0] STEP_RESET  = 3'd3;
   localparam logic [2:0] STEP_DONE   = 3'd4;

   // Error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_PROTO  = 2'd1;
   localparam logic [1:0] ERR_REMOTE = 2'd2;

   // Opcodes
   localparam logic [15:0] OPC_PSKEY  = 16'hfca0;
   localparam logic [15:0] OPC_RF     = 16'hfca2;
   localparam logic [15:0] OPC_ENABLE = 16'hfca1;
   localparam logic [15:0] OPC_RESET  = 16'h0c03;

   typedef struct packed {
      logic                   bad_start;
      logic                   ended;
      logic [FRAME_CNT_W-1:0] len;
   } frame_stat_type;

   typedef struct packed {
      logic [1:0] err;
      logic       advance;
   } check_res_type;

   function automatic logic [15:0] step_opcode(input logic [1:0] idx);
      logic [15:0] opc;
      unique case (idx)
         STEP_PSKEY[1:0]:  opc = OPC_PSKEY;
         STEP_RF[1:0]:     opc = OPC_RF;
         STEP_ENABLE[1:0]: opc = OPC_ENABLE;
         STEP_RESET[1:0]:  opc = OPC_RESET;
         default:          opc = OPC_PSKEY;
      endcase
      return opc;
   endfunction

endpackage

@@ hdl/h4sec_frame.sv @@
module h4sec_frame #(
   parameter int STORE_DEPTH = 13
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            byte_en,
   input  logic [7:0]                      rx_byte,
   output logic [STORE_DEPTH-1:0][7:0]     hdr_view,
   output h4sec_pkg::frame_stat_type       stat
);
   import h4sec_pkg::*;

   logic [FRAME_CNT_W-1:0]     count_ff, count_in;
   logic [FRAME_CNT_W-1:0]     need_ff, need_in;
   logic [FRAME_CNT_W-1:0]     count_inc, need_base, need_upd;
   logic                       bad_start, ended, take;
   logic [STORE_DEPTH-1:0][7:0] hdr_ff;

   always_comb begin
      count_inc = count_ff + 9'd1;
      need_base = (count_ff == '0) ? FRAME_HDR_LEN : need_ff;
      need_upd  = (count_inc == FRAME_HDR_LEN) ? (FRAME_HDR_LEN + {1'b0, rx_byte}) : need_base;
      ended     = (count_inc == need_upd);
      bad_start = (count_ff == '0) && (rx_byte != INDICATOR_EVT);
      take      = byte_en && !bad_start;

      count_in = count_ff;
      need_in  = need_ff;
      if (take) begin
         if (ended) begin
            count_in = '0;
            need_in  = '0;
         end else begin
            count_in = count_inc;
            need_in  = need_upd;
         end
      end

      stat.bad_start = bad_start;
      stat.ended     = ended;
      stat.len       = count_inc;

      // the byte that closes the frame is checked along with the stored ones
      for (int i = 0; i < STORE_DEPTH; i++) begin
         hdr_view[i] = (count_ff == FRAME_CNT_W'(i)) ? rx_byte : hdr_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         need_ff  <= '0;
      end else begin
         count_ff <= count_in;
         need_ff  <= need_in;
      end
   end

   // later bytes are counted only
   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (take && (count_ff == FRAME_CNT_W'(i))) begin
            hdr_ff[i] <= rx_byte;
         end
      end
   end

endmodule

@@ hdl/h4sec_check.sv @@
module h4sec_check #(
   parameter int VERSION_BYTES = 6,
   parameter int HDR_DEPTH     = 13,
   parameter int STORE_DEPTH   = 13
) (
   input  logic [STORE_DEPTH-1:0][7:0]               hdr,
   input  logic [h4sec_pkg::FRAME_CNT_W-1:0]         len,
   input  logic [2:0]                                step,
   input  logic                                      awaiting,
   input  logic [h4sec_pkg::VERSION_W-1:0]           expected_version,
   output h4sec_pkg::check_res_type                  res
);
   import h4sec_pkg::*;

   logic [VERSION_BYTES-1:0] ver_ok;
   logic                     is_cc, is_cs, len_bad, opc_match;
   logic [15:0]              opcode;
   logic [FRAME_CNT_W-1:0]   want_len;

   for (genvar g = 0; g < VERSION_BYTES; g++) begin : g_ver
      if (g < CFG_VERSION_BYTES) begin : g_cfg
         assign ver_ok[g] = (hdr[REPLY_FIXED_LEN + g] == expected_version[8*g +: 8]);
      end else begin : g_zero
         assign ver_ok[g] = (hdr[REPLY_FIXED_LEN + g] == 8'h00);
      end
   end

   always_comb begin
      is_cc     = (hdr[1] == EVT_CMD_COMPLETE);
      is_cs     = (hdr[1] == EVT_CMD_STATUS);
      len_bad   = is_cc ? (len < CC_MIN_LEN) : (len != CS_LEN);
      opcode    = is_cc ? {hdr[5], hdr[4]} : {hdr[6], hdr[5]};
      opc_match = awaiting && (step < STEP_DONE) && (opcode == step_opcode(step[1:0]));
      want_len  = (step == STEP_PSKEY) ? FRAME_CNT_W'(HDR_DEPTH) : FRAME_CNT_W'(REPLY_FIXED_LEN);

      res.err     = ERR_NONE;
      res.advance = 1'b0;
      priority if (!is_cc && !is_cs) begin
         res.err = ERR_NONE;
      end else if (len_bad) begin
         res.err = ERR_PROTO;
      end else if (!opc_match) begin
         res.err = ERR_NONE;
      end else if (is_cs) begin
         res.err = (hdr[3] != 8'h00) ? ERR_REMOTE : ERR_NONE;
      end else if (hdr[3] != 8'h01) begin
         res.err = ERR_PROTO;
      end else if (step == STEP_ENABLE) begin
         if (len != ENABLE_LEN || hdr[6] != 8'h01 || hdr[7] != 8'h00 || hdr[8] != 8'h01) begin
            res.err = ERR_PROTO;
         end else begin
            res.advance = 1'b1;
         end
      end else if (len != want_len) begin
         res.err = ERR_PROTO;
      end else if (hdr[6] != 8'h00) begin
         res.err = ERR_REMOTE;
      end else if ((step == STEP_PSKEY) && !(&ver_ok)) begin
         res.err = ERR_PROTO;
      end else begin
         res.advance = 1'b1;
      end
   end

endmodule

@@ hdl/h4_setup_event_checker.sv @@
// Channel   Dir  tdata                       tuser       tlast
// req_      in   [7:0] rx_byte               [0] mode    -
// rsp_      out  [2:0] step, [4:3] error,    -           event_end
//                [5] done_res
// csr_      in   csr_wr_data = expected_version (48 bits), written on csr_wr_en
//
// Every accepted word gives one result word; a word is taken each cycle
// unless the result stalls. A word passes the input register, then the frame
// check into the result register. The critical path is the header compare
// chain in h4sec_check. Reset is synchronous and clears counters, step and
// error; header bytes hold whatever they last saw. A stalled result holds the
// input register, which then holds req_tready low.
module h4_setup_event_checker #(
   parameter int VERSION_BYTES = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   // input words
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] rx_byte
   input  logic                             req_tuser,   // [0] mode
   // result words
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,   // [2:0] step, [4:3] error_code, [5] done_res
   output logic                             rsp_tlast,   // event_end
   // configuration
   input  logic                             csr_wr_en,
   input  logic [h4sec_pkg::VERSION_W-1:0]  csr_wr_data
);
   import h4sec_pkg::*;

   localparam int HDR_DEPTH   = REPLY_FIXED_LEN + VERSION_BYTES;
   // the ENABLE reply reads up to byte 8, so keep at least nine bytes
   localparam int STORE_DEPTH = (HDR_DEPTH > 9) ? HDR_DEPTH : 9;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_mode_ff;
   logic [7:0]            in_byte_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_step_ff;
   logic [1:0]            rsp_err_ff;
   logic                  rsp_end_ff, rsp_done_ff;
   logic [VERSION_W-1:0]  version_ff;
   logic [2:0]            step_ff, step_in;
   logic                  awaiting_ff, awaiting_in;
   logic [1:0]            error_ff, error_in;
   logic                  go, active, byte_en, ended;

   logic [STORE_DEPTH-1:0][7:0] hdr_view;
   frame_stat_type               fstat;
   check_res_type                chk;

   // advance the word when the result slot is free or being emptied
   assign go         = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || go;
   assign active     = (error_ff == ERR_NONE) && (step_ff < STEP_DONE);
   assign byte_en    = go && active && !in_mode_ff;

   h4sec_frame #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_frame (
      .clock    (clock),
      .reset    (reset),
      .byte_en  (byte_en),
      .rx_byte  (in_byte_ff),
      .hdr_view (hdr_view),
      .stat     (fstat)
   );

   h4sec_check #(
      .VERSION_BYTES (VERSION_BYTES),
      .HDR_DEPTH     (HDR_DEPTH),
      .STORE_DEPTH   (STORE_DEPTH)
   ) u_check (
      .hdr              (hdr_view),
      .len              (fstat.len),
      .step             (step_ff),
      .awaiting         (awaiting_ff),
      .expected_version (version_ff),
      .res              (chk)
   );

   always_comb begin
      step_in     = step_ff;
      awaiting_in = awaiting_ff;
      error_in    = error_ff;
      ended       = 1'b0;
      // drop everything once complete or once an error has latched
      if (go && active) begin
         if (in_mode_ff) begin
            awaiting_in = 1'b1;
         end else if (fstat.bad_start) begin
            error_in = ERR_PROTO;
         end else if (fstat.ended) begin
            ended    = 1'b1;
            error_in = chk.err;
            if (chk.advance) begin
               step_in     = step_ff + 3'd1;
               awaiting_in = 1'b0;
            end
         end
      end

      in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (go ? 1'b0 : in_valid_ff);
      rsp_valid_in = go ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_PSKEY;
         awaiting_ff  <= 1'b0;
         error_ff     <= ERR_NONE;
         version_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         awaiting_ff  <= awaiting_in;
         error_ff     <= error_in;
         if (csr_wr_en) begin
            version_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (go) begin
         rsp_step_ff <= step_in;
         rsp_err_ff  <= error_in;
         rsp_end_ff  <= ended;
         rsp_done_ff <= (step_in == STEP_DONE);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_done_ff, rsp_err_ff, rsp_step_ff};
   assign rsp_tlast  = rsp_end_ff;

endmodule

@@ hdl/h4sec_checker.sv @@
module h4sec_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   import h4sec_pkg::*;

   logic       seen_ff;
   logic [1:0] last_err_ff;
   logic [2:0] last_step_ff;
   logic       rsp_fire;

   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         last_err_ff  <= ERR_NONE;
         last_step_ff <= STEP_PSKEY;
      end else if (rsp_fire) begin
         seen_ff      <= 1'b1;
         last_err_ff  <= rsp_tdata[4:3];
         last_step_ff <= rsp_tdata[2:0];
      end
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[2:0] <= STEP_DONE) &&
                      (rsp_tdata[5] == (rsp_tdata[2:0] == STEP_DONE))))
      else $error("step out of range or done flag disagrees");

   a_error_latched: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && seen_ff && (last_err_ff != ERR_NONE)) |->
         ((rsp_tdata[4:3] == last_err_ff) && !rsp_tlast))
      else $error("latched error changed or event ended after error");

   a_step_monotonic: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && seen_ff) |->
         ((rsp_tdata[2:0] == last_step_ff) || (rsp_tdata[2:0] == last_step_ff + 3'd1)))
      else $error("step moved by other than one");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result word changed");

endmodule

bind h4_setup_event_checker h4sec_checker u_h4sec_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
